>>> src/zcl_rap_pkg.sv
package zcl_rap_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // Frame status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT_HDR = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] attr_id;
    logic [7:0]  attr_type;
    logic [7:0]  value_byte;
    logic [16:0] byte_index;
    logic        last_of_attribute;
    logic [7:0]  frame_control;
    logic [15:0] mfr_code;
    logic [7:0]  seq_num;
    logic [7:0]  cmd;
    logic [1:0]  status;
  } zcl_res_t;

  typedef enum logic [2:0] {
    SZ_FIXED,
    SZ_ZERO,
    SZ_SHORT_STR,
    SZ_LONG_STR,
    SZ_BAD
  } size_class_t;

  typedef struct packed {
    size_class_t cls;
    logic [4:0]  len;
  } type_info_t;

  // Value length of a ZCL data type code.
  function automatic type_info_t type_info(input logic [7:0] t);
    type_info_t r;
    r.cls = SZ_FIXED;
    r.len = 5'd0;
    if (t[7:3] == 5'h01 || t[7:3] == 5'h03 || t[7:3] == 5'h04 || t[7:3] == 5'h05) begin
      r.len = {2'b00, t[2:0]} + 5'd1;
    end else begin
      case (t)
        8'h10, 8'h30:        r.len = 5'd1;
        8'h31, 8'he8, 8'he9: r.len = 5'd2;
        8'he0, 8'he1, 8'he2: r.len = 5'd4;
        8'hf0:               r.len = 5'd8;
        8'hf1:               r.len = 5'd16;
        8'h00, 8'hff:        r.cls = SZ_ZERO;
        8'h41, 8'h42:        r.cls = SZ_SHORT_STR;
        8'h43, 8'h44:        r.cls = SZ_LONG_STR;
        default:             r.cls = SZ_BAD;
      endcase
    end
    return r;
  endfunction

endpackage

>>> src/zcl_rap_parse.sv
module zcl_rap_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_frame,
  output logic [1:0]           res_cnt,
  output zcl_rap_pkg::zcl_res_t res0,
  output zcl_rap_pkg::zcl_res_t res1
);
  import zcl_rap_pkg::*;

  typedef enum logic [3:0] {
    PH_FC, PH_MLO, PH_MHI, PH_SEQ, PH_CMD, PH_IDLO, PH_IDHI, PH_TYPE,
    PH_SPFX, PH_LPLO, PH_LPHI, PH_VAL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  fc_r, fc_nxt;
  logic [15:0] manuf_r, manuf_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] cur_id_r, cur_id_nxt;
  logic [7:0]  cur_type_r, cur_type_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [16:0] value_index_r, value_index_nxt;
  logic [7:0]  prefix_low_r, prefix_low_nxt;
  logic        empty_pending_r, empty_pending_nxt;
  logic [1:0]  stopped_r, stopped_nxt;

  type_info_t  tinfo;
  zcl_res_t    empty_rec, main_rec, stat_rec;
  logic        main_v;
  logic [15:0] bl_calc;
  logic        emit;
  logic        emit_last;

  assign tinfo = type_info(data_byte);

  always_comb begin
    phase_nxt         = phase_r;
    fc_nxt            = fc_r;
    manuf_nxt         = manuf_r;
    seq_nxt           = seq_r;
    cur_id_nxt        = cur_id_r;
    cur_type_nxt      = cur_type_r;
    bytes_left_nxt    = bytes_left_r;
    value_index_nxt   = value_index_r;
    prefix_low_nxt    = prefix_low_r;
    empty_pending_nxt = 1'b0;
    stopped_nxt       = stopped_r;
    main_v            = 1'b0;
    main_rec          = '0;
    emit              = 1'b0;
    emit_last         = 1'b0;
    bl_calc           = 16'd0;

    if (stopped_r == 2'd0) begin
      case (phase_r)
        PH_FC: begin
          fc_nxt    = data_byte;
          manuf_nxt = 16'd0;
          seq_nxt   = 8'd0;
          phase_nxt = data_byte[2] ? PH_MLO : PH_SEQ;
        end
        PH_MLO: begin
          manuf_nxt = {manuf_r[15:8], data_byte};
          phase_nxt = PH_MHI;
        end
        PH_MHI: begin
          manuf_nxt = {data_byte, manuf_r[7:0]};
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          seq_nxt   = data_byte;
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          main_v                 = 1'b1;
          main_rec.kind          = KIND_HEADER;
          main_rec.frame_control = fc_r;
          main_rec.mfr_code      = manuf_r;
          main_rec.seq_num       = seq_r;
          main_rec.cmd           = data_byte;
          phase_nxt              = PH_IDLO;
        end
        PH_IDLO: begin
          cur_id_nxt = {8'd0, data_byte};
          phase_nxt  = PH_IDHI;
        end
        PH_IDHI: begin
          cur_id_nxt = {data_byte, cur_id_r[7:0]};
          phase_nxt  = PH_TYPE;
        end
        PH_TYPE: begin
          cur_type_nxt    = data_byte;
          value_index_nxt = 17'd0;
          if (!end_of_frame) begin
            case (tinfo.cls)
              SZ_BAD:       stopped_nxt = ST_BAD_TYPE;
              SZ_SHORT_STR: phase_nxt = PH_SPFX;
              SZ_LONG_STR:  phase_nxt = PH_LPLO;
              SZ_ZERO: begin
                empty_pending_nxt = 1'b1;
                phase_nxt         = PH_IDLO;
              end
              default: begin
                bytes_left_nxt = {11'd0, tinfo.len};
                phase_nxt      = PH_VAL;
              end
            endcase
          end
        end
        PH_SPFX: begin
          bl_calc        = {8'd0, data_byte};
          bytes_left_nxt = bl_calc;
          emit           = 1'b1;
          emit_last      = (bl_calc == 16'd0);
          phase_nxt      = emit_last ? PH_IDLO : PH_VAL;
        end
        PH_LPLO: begin
          prefix_low_nxt = data_byte;
          emit           = 1'b1;
          phase_nxt      = PH_LPHI;
        end
        PH_LPHI: begin
          bl_calc        = {data_byte, prefix_low_r};
          bytes_left_nxt = bl_calc;
          emit           = 1'b1;
          emit_last      = (bl_calc == 16'd0);
          phase_nxt      = emit_last ? PH_IDLO : PH_VAL;
        end
        PH_VAL: begin
          bl_calc        = bytes_left_r - 16'd1;
          bytes_left_nxt = bl_calc;
          emit           = 1'b1;
          emit_last      = (bl_calc == 16'd0);
          if (emit_last) begin
            phase_nxt = PH_IDLO;
          end
        end
        default: phase_nxt = PH_FC;
      endcase
    end

    if (emit) begin
      main_v                     = 1'b1;
      main_rec.kind              = KIND_VALUE;
      main_rec.attr_id           = cur_id_r;
      main_rec.attr_type         = cur_type_r;
      main_rec.value_byte        = data_byte;
      main_rec.byte_index        = value_index_r;
      main_rec.last_of_attribute = emit_last;
      value_index_nxt            = value_index_r + 17'd1;
    end

    empty_rec           = '0;
    empty_rec.kind      = KIND_EMPTY;
    empty_rec.attr_id   = cur_id_r;
    empty_rec.attr_type = cur_type_r;

    stat_rec      = '0;
    stat_rec.kind = KIND_STATUS;
    if (stopped_nxt != 2'd0) begin
      stat_rec.status = stopped_nxt;
    end else if (phase_nxt <= PH_CMD) begin
      stat_rec.status = ST_SHORT_HDR;
    end else if (phase_nxt >= PH_SPFX) begin
      stat_rec.status = ST_TRUNC;
    end else begin
      stat_rec.status = ST_OK;
    end

    // Frame end: drop all parse state back to its idle value
    if (end_of_frame) begin
      phase_nxt         = PH_FC;
      fc_nxt            = 8'd0;
      manuf_nxt         = 16'd0;
      seq_nxt           = 8'd0;
      cur_id_nxt        = 16'd0;
      cur_type_nxt      = 8'd0;
      bytes_left_nxt    = 16'd0;
      value_index_nxt   = 17'd0;
      prefix_low_nxt    = 8'd0;
      empty_pending_nxt = 1'b0;
      stopped_nxt       = 2'd0;
    end
  end

  // Pack results; an empty-attribute result and a main result never coincide.
  always_comb begin
    res0    = empty_pending_r ? empty_rec : (main_v ? main_rec : stat_rec);
    res1    = stat_rec;
    res_cnt = {1'b0, empty_pending_r} + {1'b0, main_v} + {1'b0, end_of_frame};
    if (!accept) begin
      res_cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_FC;
      fc_r            <= 8'd0;
      manuf_r         <= 16'd0;
      seq_r           <= 8'd0;
      cur_id_r        <= 16'd0;
      cur_type_r      <= 8'd0;
      bytes_left_r    <= 16'd0;
      value_index_r   <= 17'd0;
      prefix_low_r    <= 8'd0;
      empty_pending_r <= 1'b0;
      stopped_r       <= 2'd0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      fc_r            <= fc_nxt;
      manuf_r         <= manuf_nxt;
      seq_r           <= seq_nxt;
      cur_id_r        <= cur_id_nxt;
      cur_type_r      <= cur_type_nxt;
      bytes_left_r    <= bytes_left_nxt;
      value_index_r   <= value_index_nxt;
      prefix_low_r    <= prefix_low_nxt;
      empty_pending_r <= empty_pending_nxt;
      stopped_r       <= stopped_nxt;
    end
  end

endmodule

>>> src/zcl_rap_queue.sv
module zcl_rap_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_cnt,
  input  zcl_rap_pkg::zcl_res_t push0,
  input  zcl_rap_pkg::zcl_res_t push1,
  output logic                 full2,
  output logic                 head_valid,
  input  logic                 pop,
  output zcl_rap_pkg::zcl_res_t head
);
  import zcl_rap_pkg::*;

  zcl_res_t         mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;
  logic             do_pop;
  logic [QPtrW-1:0] wr_ptr1;

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  // Hold off input unless two free slots remain
  assign full2      = (count_r > QCntW'(QDepth - 2));
  assign do_pop     = pop && head_valid;
  assign wr_ptr1    = wr_ptr_r + QPtrW'(1);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPtrW'(push_cnt);
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      count_r <= count_r + QCntW'(push_cnt) - QCntW'(do_pop);
    end
  end

endmodule

>>> src/zcl_report_attribute_parser.sv
// ZCL attribute report parser. Takes one frame byte per transaction and
// decodes the header (frame control, optional manufacturer code, sequence
// number, command), then splits the payload into attribute records and emits
// one result transaction per value byte and per string length-prefix byte,
// plus a header result on the command byte, an empty-attribute result ahead
// of the byte that follows a zero-length type, and a status result on the
// final byte. A byte is taken every cycle while the queue has room; each
// accepted byte writes up to two results into a four-entry result queue,
// registered before the outputs, that gives one transaction per cycle while
// out_stall is low. Input stalls while fewer than two queue slots are free,
// so sustained input rate is one byte per cycle unless bytes that give two
// results arrive faster than the output side drains them.
module zcl_report_attribute_parser (
  input  logic        clk,
  input  logic        rst_n,
  // Frame byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_frame,
  // Result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_attr_id,
  output logic [7:0]  out_attr_type,
  output logic [7:0]  out_value_byte,
  output logic [16:0] out_byte_index,
  output logic        out_last_of_attribute,
  output logic [7:0]  out_frame_control,
  output logic [15:0] out_mfr_code,
  output logic [7:0]  out_seq_num,
  output logic [7:0]  out_cmd,
  output logic [1:0]  out_status
);
  import zcl_rap_pkg::*;

  logic     in_accept;
  logic     q_full2;
  logic [1:0] res_cnt;
  zcl_res_t res0, res1, head;

  // Stall depends only on queue occupancy, never on in_valid
  assign in_stall  = q_full2;
  assign in_accept = in_valid && !q_full2;

  // Parse state machine: one byte in, up to two results out
  zcl_rap_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .data_byte    (in_data_byte),
    .end_of_frame (in_end_of_frame),
    .res_cnt      (res_cnt),
    .res0         (res0),
    .res1         (res1)
  );

  // Result queue: decouple the two results of one byte from the output rate
  zcl_rap_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (res_cnt),
    .push0      (res0),
    .push1      (res1),
    .full2      (q_full2),
    .head_valid (out_valid),
    .pop        (!out_stall),
    .head       (head)
  );

  assign out_kind              = head.kind;
  assign out_attr_id           = head.attr_id;
  assign out_attr_type         = head.attr_type;
  assign out_value_byte        = head.value_byte;
  assign out_byte_index        = head.byte_index;
  assign out_last_of_attribute = head.last_of_attribute;
  assign out_frame_control     = head.frame_control;
  assign out_mfr_code          = head.mfr_code;
  assign out_seq_num           = head.seq_num;
  assign out_cmd               = head.cmd;
  assign out_status            = head.status;

endmodule
